// ===== hw/rtl/cecpwr_pkg.sv =====
package cecpwr_pkg;

  localparam int DEF_MAX_ATTEMPTS = 15;
  localparam int DEF_WAIT_BITS    = 16;

  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAKE_LIMIT    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STANDBY_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEND_TIMEOUT  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RETRY_DELAY   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAKE_DELAY    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POWER_TIMEOUT = 3'd5;

  localparam logic [3:0]  RST_WAKE_LIMIT    = 4'd3;
  localparam logic [3:0]  RST_STANDBY_LIMIT = 4'd3;
  localparam logic [15:0] RST_SEND_TIMEOUT  = 16'd1000;
  localparam logic [15:0] RST_RETRY_DELAY   = 16'd200;
  localparam logic [15:0] RST_WAKE_DELAY    = 16'd500;
  localparam logic [15:0] RST_POWER_TIMEOUT = 16'd1000;

  // input event kinds
  localparam logic [2:0] EV_START_ON      = 3'd0;
  localparam logic [2:0] EV_START_STANDBY = 3'd1;
  localparam logic [2:0] EV_START_STATUS  = 3'd2;
  localparam logic [2:0] EV_SEND_DONE     = 3'd3;
  localparam logic [2:0] EV_DELAY_DONE    = 3'd4;
  localparam logic [2:0] EV_POWER_REPLY   = 3'd5;

  // transmit outcomes
  localparam logic [1:0] TX_ACK         = 2'd0;
  localparam logic [1:0] TX_NO_ACK      = 2'd1;
  localparam logic [1:0] TX_EXPIRED     = 2'd2;
  localparam logic [1:0] TX_UNAVAILABLE = 2'd3;

  // power query outcomes
  localparam logic [2:0] QRY_OK               = 3'd0;
  localparam logic [2:0] QRY_NO_ACK           = 3'd1;
  localparam logic [2:0] QRY_SEND_TIMEOUT     = 3'd2;
  localparam logic [2:0] QRY_RESPONSE_TIMEOUT = 3'd3;

  // result codes
  localparam logic [2:0] RC_OK               = 3'd0;
  localparam logic [2:0] RC_INVALID_PHYSICAL = 3'd1;
  localparam logic [2:0] RC_NO_ACK           = 3'd2;
  localparam logic [2:0] RC_SEND_TIMEOUT     = 3'd3;
  localparam logic [2:0] RC_RESPONSE_TIMEOUT = 3'd4;
  localparam logic [2:0] RC_UNAVAILABLE      = 3'd5;

  // output word kinds
  localparam logic [1:0] OUT_SEND  = 2'd0;
  localparam logic [1:0] OUT_DELAY = 2'd1;
  localparam logic [1:0] OUT_QUERY = 2'd2;
  localparam logic [1:0] OUT_FINAL = 2'd3;

  // CEC opcodes and addresses
  localparam logic [7:0] OPC_IMAGE_VIEW_ON   = 8'h04;
  localparam logic [7:0] OPC_STANDBY         = 8'h36;
  localparam logic [7:0] OPC_ACTIVE_SOURCE   = 8'h82;
  localparam logic [7:0] OPC_REPORT_PHYSICAL = 8'h84;
  localparam logic [3:0] LA_TV               = 4'h0;
  localparam logic [3:0] LA_BROADCAST        = 4'hf;
  localparam logic [7:0] POWER_UNKNOWN       = 8'hff;

  localparam logic [2:0] LEN_SHORT  = 3'd2;
  localparam logic [2:0] LEN_ACTIVE = 3'd4;
  localparam logic [2:0] LEN_REPORT = 3'd5;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_REPORT     = 4'd1,
    PH_WAKE       = 4'd2,
    PH_WAKE_RETRY = 4'd3,
    PH_WAKE_DELAY = 4'd4,
    PH_ACTIVE     = 4'd5,
    PH_SB_SEND    = 4'd6,
    PH_SB_RETRY   = 4'd7,
    PH_STATUS     = 4'd8
  } phase_t;

endpackage

// ===== hw/rtl/cec_power_command_sequencer_core.sv =====
// CEC power command sequencer: one touch play, standby and power status.
// Input channel (in_valid/in_ready) carries one event word: a start command,
// a transmit outcome, a delay completion or a power status reply. Output
// channel (out_valid/out_ready) carries at most one word per event: a send
// request, a delay request, a power query request or a final result.
// Events with no meaning in the current phase produce no word.
// An accepted event lands in an input register; when that register advances,
// the event is decoded against the phase and counters and its word, if any, is
// written to the output register, which drives out_valid and holds the word
// until it is taken.
// Throughput is one event per cycle, limited by the single output register:
// the event register advances whenever the output register is empty or is
// being taken in the same cycle.
// When the receiver stalls, the output word holds, one more event waits in
// the input register, and in_ready drops.
// Reset (rst, synchronous) returns to idle, clears both registers and loads
// the default limits and timeouts. Write registers through cfg_we/cfg_index/
// cfg_data only while the block is idle.
module cec_power_command_sequencer_core #(
  parameter int MAX_ATTEMPTS = cecpwr_pkg::DEF_MAX_ATTEMPTS,
  parameter int WAIT_BITS    = cecpwr_pkg::DEF_WAIT_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [cecpwr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cecpwr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0]                            kind,
  input  logic [3:0]                            cec_addr,
  input  logic [15:0]                           phys_addr,
  input  logic [7:0]                            dev_type,
  input  logic [1:0]                            send_outcome,
  input  logic [2:0]                            query_outcome,
  input  logic [7:0]                            reported_power,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_kind,
  output logic [7:0]                            header,
  output logic [7:0]                            opcode,
  output logic [7:0]                            operand_a,
  output logic [7:0]                            operand_b,
  output logic [7:0]                            operand_c,
  output logic [2:0]                            message_length,
  output logic [WAIT_BITS-1:0]                  wait_ms,
  output logic [2:0]                            result_code,
  output logic [1:0]                            last_outcome,
  output logic [3:0]                            attempt_count,
  output logic [7:0]                            power_state
);
  import cecpwr_pkg::*;

  localparam logic [3:0] LIMIT_CAP = (MAX_ATTEMPTS > 15) ? 4'd15 : 4'(MAX_ATTEMPTS);

  function automatic logic [3:0] eff_limit(input logic [3:0] r);
    logic [3:0] l;
    l = r;
    if (l > LIMIT_CAP) l = LIMIT_CAP;
    if (l == 4'd0) l = 4'd1;
    return l;
  endfunction

  function automatic logic valid_physical(input logic [15:0] pa);
    logic z3, z2, z1;
    z3 = (pa[15:12] == 4'd0);
    z2 = (pa[11:8] == 4'd0);
    z1 = (pa[7:4] == 4'd0);
    return !(pa == 16'h0000 || pa == 16'hffff ||
             (z3 && pa[11:0] != 12'd0) ||
             (z2 && pa[7:0] != 8'd0) ||
             (z1 && pa[3:0] != 4'd0));
  endfunction

  // configuration
  logic [3:0]  wake_limit;
  logic [3:0]  standby_limit;
  logic [15:0] send_timeout;
  logic [15:0] retry_delay;
  logic [15:0] wake_delay;
  logic [15:0] power_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_limit    <= RST_WAKE_LIMIT;
      standby_limit <= RST_STANDBY_LIMIT;
      send_timeout  <= RST_SEND_TIMEOUT;
      retry_delay   <= RST_RETRY_DELAY;
      wake_delay    <= RST_WAKE_DELAY;
      power_timeout <= RST_POWER_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WAKE_LIMIT:    wake_limit    <= cfg_data[3:0];
        REG_STANDBY_LIMIT: standby_limit <= cfg_data[3:0];
        REG_SEND_TIMEOUT:  send_timeout  <= cfg_data;
        REG_RETRY_DELAY:   retry_delay   <= cfg_data;
        REG_WAKE_DELAY:    wake_delay    <= cfg_data;
        REG_POWER_TIMEOUT: power_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic        ev_valid;
  logic [2:0]  ev_kind;
  logic [3:0]  ev_la;
  logic [15:0] ev_pa;
  logic [7:0]  ev_dt;
  logic [1:0]  ev_tx;
  logic [2:0]  ev_q;
  logic [7:0]  ev_pw;
  logic        advance;

  assign advance  = ev_valid && (!out_valid || out_ready);
  assign in_ready = !ev_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (in_ready) begin
      ev_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      ev_kind <= kind;
      ev_la   <= cec_addr;
      ev_pa   <= phys_addr;
      ev_dt   <= dev_type;
      ev_tx   <= send_outcome;
      ev_q    <= query_outcome;
      ev_pw   <= reported_power;
    end
  end

  // sequencer state
  phase_t      phase, phase_next;
  logic [3:0]  attempts_made, attempts_made_next;
  logic [3:0]  own_address, own_address_next;
  logic [15:0] held_physical, held_physical_next;
  logic [1:0]  wake_outcome, wake_outcome_next;

  logic la_ok, pa_ok, tx_delivered, wake_retry, sb_retry;

  assign la_ok        = (ev_la != 4'd0) && (ev_la != 4'hf);
  assign pa_ok        = valid_physical(ev_pa);
  assign tx_delivered = (ev_tx == TX_ACK) || (ev_tx == TX_NO_ACK);
  assign wake_retry   = (ev_tx != TX_ACK) && (attempts_made < eff_limit(wake_limit));
  assign sb_retry     = attempts_made < eff_limit(standby_limit);

  always_comb begin
    phase_next         = phase;
    attempts_made_next = attempts_made;
    own_address_next   = own_address;
    held_physical_next = held_physical;
    wake_outcome_next  = wake_outcome;
    unique case (phase)
      PH_IDLE: begin
        if (ev_kind <= EV_START_STATUS && la_ok) begin
          own_address_next   = ev_la;
          attempts_made_next = 4'd0;
          if (ev_kind == EV_START_ON) begin
            if (pa_ok) begin
              held_physical_next = ev_pa;
              wake_outcome_next  = TX_UNAVAILABLE;
              phase_next         = PH_REPORT;
            end
          end else if (ev_kind == EV_START_STANDBY) begin
            attempts_made_next = 4'd1;
            phase_next         = PH_SB_SEND;
          end else begin
            phase_next = PH_STATUS;
          end
        end
      end
      PH_REPORT: begin
        if (ev_kind == EV_SEND_DONE) begin
          if (tx_delivered) begin
            attempts_made_next = 4'd1;
            phase_next         = PH_WAKE;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_WAKE: begin
        if (ev_kind == EV_SEND_DONE) begin
          wake_outcome_next = ev_tx;
          if (ev_tx == TX_UNAVAILABLE) phase_next = PH_IDLE;
          else if (wake_retry)         phase_next = PH_WAKE_RETRY;
          else                         phase_next = PH_WAKE_DELAY;
        end
      end
      PH_WAKE_RETRY: begin
        if (ev_kind == EV_DELAY_DONE) begin
          attempts_made_next = attempts_made + 4'd1;
          phase_next         = PH_WAKE;
        end
      end
      PH_WAKE_DELAY: begin
        if (ev_kind == EV_DELAY_DONE) phase_next = PH_ACTIVE;
      end
      PH_ACTIVE: begin
        if (ev_kind == EV_SEND_DONE) phase_next = PH_IDLE;
      end
      PH_SB_SEND: begin
        if (ev_kind == EV_SEND_DONE) begin
          if (ev_tx != TX_ACK && ev_tx != TX_UNAVAILABLE && sb_retry) phase_next = PH_SB_RETRY;
          else                                                        phase_next = PH_IDLE;
        end
      end
      PH_SB_RETRY: begin
        if (ev_kind == EV_DELAY_DONE) begin
          attempts_made_next = attempts_made + 4'd1;
          phase_next         = PH_SB_SEND;
        end
      end
      PH_STATUS: begin
        if (ev_kind == EV_POWER_REPLY) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // result word for the event in the input register
  logic                 res_emit;
  logic [1:0]           res_kind;
  logic [7:0]           res_header, res_opcode, res_a, res_b, res_c;
  logic [2:0]           res_len;
  logic [WAIT_BITS-1:0] res_wait;
  logic [2:0]           res_code;
  logic [1:0]           res_outcome;
  logic [3:0]           res_count;
  logic [7:0]           res_power;

  always_comb begin
    res_emit    = 1'b0;
    res_kind    = OUT_SEND;
    res_header  = 8'd0;
    res_opcode  = 8'd0;
    res_a       = 8'd0;
    res_b       = 8'd0;
    res_c       = 8'd0;
    res_len     = 3'd0;
    res_wait    = '0;
    res_code    = RC_OK;
    res_outcome = TX_ACK;
    res_count   = 4'd0;
    res_power   = 8'd0;
    unique case (phase)
      PH_IDLE: begin
        if (ev_kind <= EV_START_STATUS) begin
          res_emit = 1'b1;
          if (!la_ok || (ev_kind == EV_START_ON && !pa_ok)) begin
            res_kind    = OUT_FINAL;
            res_code    = la_ok ? RC_INVALID_PHYSICAL : RC_UNAVAILABLE;
            res_outcome = TX_UNAVAILABLE;
            res_power   = POWER_UNKNOWN;
          end else if (ev_kind == EV_START_ON) begin
            res_header = {ev_la, LA_BROADCAST};
            res_opcode = OPC_REPORT_PHYSICAL;
            res_a      = ev_pa[15:8];
            res_b      = ev_pa[7:0];
            res_c      = ev_dt;
            res_len    = LEN_REPORT;
            res_wait   = WAIT_BITS'(send_timeout);
          end else if (ev_kind == EV_START_STANDBY) begin
            res_header = {ev_la, LA_TV};
            res_opcode = OPC_STANDBY;
            res_len    = LEN_SHORT;
            res_wait   = WAIT_BITS'(send_timeout);
          end else begin
            res_kind   = OUT_QUERY;
            res_header = {ev_la, 4'd0};
            res_wait   = WAIT_BITS'(power_timeout);
          end
        end
      end
      PH_REPORT: begin
        if (ev_kind == EV_SEND_DONE) begin
          res_emit = 1'b1;
          if (tx_delivered) begin
            res_header = {own_address, LA_TV};
            res_opcode = OPC_IMAGE_VIEW_ON;
            res_len    = LEN_SHORT;
            res_wait   = WAIT_BITS'(send_timeout);
          end else begin
            res_kind    = OUT_FINAL;
            res_code    = (ev_tx == TX_EXPIRED) ? RC_SEND_TIMEOUT : RC_UNAVAILABLE;
            res_outcome = ev_tx;
            res_power   = POWER_UNKNOWN;
          end
        end
      end
      PH_WAKE: begin
        if (ev_kind == EV_SEND_DONE) begin
          res_emit = 1'b1;
          if (ev_tx == TX_UNAVAILABLE) begin
            res_kind    = OUT_FINAL;
            res_code    = RC_UNAVAILABLE;
            res_outcome = ev_tx;
            res_count   = attempts_made;
            res_power   = POWER_UNKNOWN;
          end else begin
            res_kind = OUT_DELAY;
            res_wait = wake_retry ? WAIT_BITS'(retry_delay) : WAIT_BITS'(wake_delay);
          end
        end
      end
      PH_WAKE_RETRY, PH_SB_RETRY: begin
        if (ev_kind == EV_DELAY_DONE) begin
          res_emit   = 1'b1;
          res_header = {own_address, LA_TV};
          res_opcode = (phase == PH_WAKE_RETRY) ? OPC_IMAGE_VIEW_ON : OPC_STANDBY;
          res_len    = LEN_SHORT;
          res_wait   = WAIT_BITS'(send_timeout);
        end
      end
      PH_WAKE_DELAY: begin
        if (ev_kind == EV_DELAY_DONE) begin
          res_emit   = 1'b1;
          res_header = {own_address, LA_BROADCAST};
          res_opcode = OPC_ACTIVE_SOURCE;
          res_a      = held_physical[15:8];
          res_b      = held_physical[7:0];
          res_len    = LEN_ACTIVE;
          res_wait   = WAIT_BITS'(send_timeout);
        end
      end
      PH_ACTIVE: begin
        if (ev_kind == EV_SEND_DONE) begin
          res_emit  = 1'b1;
          res_kind  = OUT_FINAL;
          res_count = attempts_made;
          res_power = POWER_UNKNOWN;
          if (!tx_delivered) begin
            res_code    = (ev_tx == TX_EXPIRED) ? RC_SEND_TIMEOUT : RC_UNAVAILABLE;
            res_outcome = ev_tx;
          end else begin
            // final code follows the last Image View On outcome
            res_outcome = wake_outcome;
            unique case (wake_outcome)
              TX_ACK:         res_code = RC_OK;
              TX_EXPIRED:     res_code = RC_SEND_TIMEOUT;
              TX_UNAVAILABLE: res_code = RC_UNAVAILABLE;
              default:        res_code = RC_NO_ACK;
            endcase
          end
        end
      end
      PH_SB_SEND: begin
        if (ev_kind == EV_SEND_DONE) begin
          res_emit = 1'b1;
          if (ev_tx != TX_ACK && ev_tx != TX_UNAVAILABLE && sb_retry) begin
            res_kind = OUT_DELAY;
            res_wait = WAIT_BITS'(retry_delay);
          end else begin
            res_kind    = OUT_FINAL;
            res_outcome = ev_tx;
            res_count   = attempts_made;
            res_power   = POWER_UNKNOWN;
            unique case (ev_tx)
              TX_ACK:         res_code = RC_OK;
              TX_EXPIRED:     res_code = RC_SEND_TIMEOUT;
              TX_UNAVAILABLE: res_code = RC_UNAVAILABLE;
              default:        res_code = RC_NO_ACK;
            endcase
          end
        end
      end
      PH_STATUS: begin
        if (ev_kind == EV_POWER_REPLY) begin
          res_emit  = 1'b1;
          res_kind  = OUT_FINAL;
          res_count = 4'd1;
          res_power = ev_pw;
          unique case (ev_q)
            QRY_OK: begin
              res_code    = RC_OK;
              res_outcome = TX_ACK;
            end
            QRY_NO_ACK: begin
              res_code    = RC_NO_ACK;
              res_outcome = TX_NO_ACK;
            end
            QRY_SEND_TIMEOUT: begin
              res_code    = RC_SEND_TIMEOUT;
              res_outcome = TX_EXPIRED;
            end
            QRY_RESPONSE_TIMEOUT: begin
              res_code    = RC_RESPONSE_TIMEOUT;
              res_outcome = TX_ACK;
            end
            default: begin
              res_code    = RC_UNAVAILABLE;
              res_outcome = TX_UNAVAILABLE;
            end
          endcase
        end
      end
      default: res_emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      attempts_made <= 4'd0;
      own_address   <= 4'd0;
      held_physical <= 16'd0;
      wake_outcome  <= TX_UNAVAILABLE;
    end else if (advance) begin
      phase         <= phase_next;
      attempts_made <= attempts_made_next;
      own_address   <= own_address_next;
      held_physical <= held_physical_next;
      wake_outcome  <= wake_outcome_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (advance && res_emit) || (out_valid && !out_ready);
    end
    if (advance && res_emit) begin
      out_kind       <= res_kind;
      header         <= res_header;
      opcode         <= res_opcode;
      operand_a      <= res_a;
      operand_b      <= res_b;
      operand_c      <= res_c;
      message_length <= res_len;
      wait_ms        <= res_wait;
      result_code    <= res_code;
      last_outcome   <= res_outcome;
      attempt_count  <= res_count;
      power_state    <= res_power;
    end
  end

endmodule

// ===== sim/cecpwr_sequence_checker.sv =====
module cecpwr_sequence_checker #(
  parameter int MAX_ATTEMPTS = cecpwr_pkg::DEF_MAX_ATTEMPTS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [cecpwr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cecpwr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [2:0]                            ev_kind,
  input  logic [3:0]                            ev_la,
  input  logic [15:0]                           ev_pa,
  input  logic [7:0]                            ev_dtype,
  input  logic [1:0]                            ev_tx,
  input  logic [2:0]                            ev_query,
  input  logic [7:0]                            ev_power,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [1:0]                            out_kind,
  input  logic [7:0]                            header,
  input  logic [7:0]                            opcode,
  input  logic [7:0]                            operand_a,
  input  logic [7:0]                            operand_b,
  input  logic [7:0]                            operand_c,
  input  logic [2:0]                            message_length,
  input  logic [cecpwr_pkg::DEF_WAIT_BITS-1:0]  wait_ms,
  input  logic [2:0]                            result_code,
  input  logic [1:0]                            last_outcome,
  input  logic [3:0]                            attempt_count,
  input  logic [7:0]                            power_state,
  output int                                    mismatches,
  output int                                    outstanding,
  output int                                    predicted,
  output int                                    checked
);
  import cecpwr_pkg::*;

  typedef struct packed {
    logic [1:0]               out_kind;
    logic [7:0]               header;
    logic [7:0]               opcode;
    logic [7:0]               op_a;
    logic [7:0]               op_b;
    logic [7:0]               op_c;
    logic [2:0]               msg_len;
    logic [DEF_WAIT_BITS-1:0] wait_ms;
    logic [2:0]               code;
    logic [1:0]               outcome;
    logic [3:0]               attempts;
    logic [7:0]               power;
  } word_t;

  // sequencer shadow state
  phase_t      seq_phase;
  logic [3:0]  attempts;
  logic [3:0]  own_la;
  logic [15:0] held_pa;
  logic [1:0]  wake_tx;

  // register copies
  logic [3:0]  wake_lim, sb_lim;
  logic [15:0] send_to, retry_dly, wake_dly, power_to;

  word_t due_words[$];
  word_t due_w, seen_w, next_w;
  int    err_cnt = 0;
  int    predicted_cnt = 0;
  int    checked_cnt = 0;

  function automatic logic [3:0] attempt_cap(input logic [3:0] lim);
    int l;
    l = lim;
    if (l > MAX_ATTEMPTS) l = MAX_ATTEMPTS;
    if (l == 0) l = 1;
    return l[3:0];
  endfunction

  // a valid physical address is not 0000 or ffff and has no nonzero nibble below a zero nibble
  function automatic bit pa_ok(input logic [15:0] pa);
    bit hole;
    hole = 1'b0;
    if (pa == 16'h0000 || pa == 16'hffff) return 1'b0;
    for (int s = 3; s >= 0; s--) begin
      if (hole && pa[s*4 +: 4] != 4'h0) return 1'b0;
      if (pa[s*4 +: 4] == 4'h0) hole = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic word_t send_word(input logic [3:0] dest, input logic [7:0] opc,
                                      input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [2:0] len);
    word_t w;
    w = '0;
    w.out_kind = OUT_SEND;
    w.header   = {own_la, dest};
    w.opcode   = opc;
    w.op_a     = a;
    w.op_b     = b;
    w.op_c     = c;
    w.msg_len  = len;
    w.wait_ms  = send_to;
    return w;
  endfunction

  function automatic word_t delay_word(input logic [15:0] ms);
    word_t w;
    w = '0;
    w.out_kind = OUT_DELAY;
    w.wait_ms  = ms;
    return w;
  endfunction

  // a final result always drops the sequencer back to idle
  function automatic word_t final_word(input logic [2:0] rc, input logic [1:0] tx,
                                       input logic [3:0] n, input logic [7:0] pw);
    word_t w;
    w = '0;
    w.out_kind = OUT_FINAL;
    w.code     = rc;
    w.outcome  = tx;
    w.attempts = n;
    w.power    = pw;
    seq_phase  = PH_IDLE;
    return w;
  endfunction

  function automatic bit sequence_step(input logic [2:0] k, input logic [3:0] la,
                                       input logic [15:0] pa, input logic [7:0] dt,
                                       input logic [1:0] tx, input logic [2:0] q,
                                       input logic [7:0] pw, output word_t w);
    w = '0;
    if (seq_phase == PH_IDLE) begin
      if (k > EV_START_STATUS) return 1'b0;
      if (la == LA_TV || la == LA_BROADCAST) begin
        w = final_word(RC_UNAVAILABLE, TX_UNAVAILABLE, 4'd0, POWER_UNKNOWN);
        return 1'b1;
      end
      own_la   = la;
      attempts = 4'd0;
      case (k)
        EV_START_ON: begin
          if (!pa_ok(pa)) begin
            w = final_word(RC_INVALID_PHYSICAL, TX_UNAVAILABLE, 4'd0, POWER_UNKNOWN);
          end else begin
            held_pa   = pa;
            wake_tx   = TX_UNAVAILABLE;
            seq_phase = PH_REPORT;
            w = send_word(LA_BROADCAST, OPC_REPORT_PHYSICAL, pa[15:8], pa[7:0], dt, LEN_REPORT);
          end
        end
        EV_START_STANDBY: begin
          attempts  = 4'd1;
          seq_phase = PH_SB_SEND;
          w = send_word(LA_TV, OPC_STANDBY, 8'h00, 8'h00, 8'h00, LEN_SHORT);
        end
        default: begin
          seq_phase  = PH_STATUS;
          w.out_kind = OUT_QUERY;
          w.header   = {own_la, 4'h0};
          w.wait_ms  = power_to;
        end
      endcase
      return 1'b1;
    end

    case (seq_phase)
      PH_REPORT: begin
        if (k != EV_SEND_DONE) return 1'b0;
        if (tx == TX_EXPIRED || tx == TX_UNAVAILABLE) begin
          w = final_word(tx == TX_EXPIRED ? RC_SEND_TIMEOUT : RC_UNAVAILABLE, tx, 4'd0,
                         POWER_UNKNOWN);
        end else begin
          attempts  = 4'd1;
          seq_phase = PH_WAKE;
          w = send_word(LA_TV, OPC_IMAGE_VIEW_ON, 8'h00, 8'h00, 8'h00, LEN_SHORT);
        end
      end
      PH_WAKE: begin
        if (k != EV_SEND_DONE) return 1'b0;
        wake_tx = tx;
        if (tx == TX_UNAVAILABLE) begin
          w = final_word(RC_UNAVAILABLE, tx, attempts, POWER_UNKNOWN);
        end else if (tx != TX_ACK && attempts < attempt_cap(wake_lim)) begin
          seq_phase = PH_WAKE_RETRY;
          w = delay_word(retry_dly);
        end else begin
          seq_phase = PH_WAKE_DELAY;
          w = delay_word(wake_dly);
        end
      end
      PH_WAKE_RETRY: begin
        if (k != EV_DELAY_DONE) return 1'b0;
        attempts  = attempts + 4'd1;
        seq_phase = PH_WAKE;
        w = send_word(LA_TV, OPC_IMAGE_VIEW_ON, 8'h00, 8'h00, 8'h00, LEN_SHORT);
      end
      PH_WAKE_DELAY: begin
        if (k != EV_DELAY_DONE) return 1'b0;
        seq_phase = PH_ACTIVE;
        w = send_word(LA_BROADCAST, OPC_ACTIVE_SOURCE, held_pa[15:8], held_pa[7:0], 8'h00,
                      LEN_ACTIVE);
      end
      PH_ACTIVE: begin
        if (k != EV_SEND_DONE) return 1'b0;
        if (tx == TX_EXPIRED || tx == TX_UNAVAILABLE) begin
          w = final_word(tx == TX_EXPIRED ? RC_SEND_TIMEOUT : RC_UNAVAILABLE, tx, attempts,
                         POWER_UNKNOWN);
        end else begin
          // the Image View On outcome decides the verdict
          case (wake_tx)
            TX_ACK:         w = final_word(RC_OK, TX_ACK, attempts, POWER_UNKNOWN);
            TX_EXPIRED:     w = final_word(RC_SEND_TIMEOUT, wake_tx, attempts, POWER_UNKNOWN);
            TX_UNAVAILABLE: w = final_word(RC_UNAVAILABLE, wake_tx, attempts, POWER_UNKNOWN);
            default:        w = final_word(RC_NO_ACK, wake_tx, attempts, POWER_UNKNOWN);
          endcase
        end
      end
      PH_SB_SEND: begin
        if (k != EV_SEND_DONE) return 1'b0;
        if (tx == TX_ACK) begin
          w = final_word(RC_OK, tx, attempts, POWER_UNKNOWN);
        end else if (tx == TX_UNAVAILABLE) begin
          w = final_word(RC_UNAVAILABLE, tx, attempts, POWER_UNKNOWN);
        end else if (attempts < attempt_cap(sb_lim)) begin
          seq_phase = PH_SB_RETRY;
          w = delay_word(retry_dly);
        end else begin
          w = final_word(tx == TX_EXPIRED ? RC_SEND_TIMEOUT : RC_NO_ACK, tx, attempts,
                         POWER_UNKNOWN);
        end
      end
      PH_SB_RETRY: begin
        if (k != EV_DELAY_DONE) return 1'b0;
        attempts  = attempts + 4'd1;
        seq_phase = PH_SB_SEND;
        w = send_word(LA_TV, OPC_STANDBY, 8'h00, 8'h00, 8'h00, LEN_SHORT);
      end
      PH_STATUS: begin
        if (k != EV_POWER_REPLY) return 1'b0;
        case (q)
          QRY_OK:               w = final_word(RC_OK, TX_ACK, 4'd1, pw);
          QRY_NO_ACK:           w = final_word(RC_NO_ACK, TX_NO_ACK, 4'd1, pw);
          QRY_SEND_TIMEOUT:     w = final_word(RC_SEND_TIMEOUT, TX_EXPIRED, 4'd1, pw);
          QRY_RESPONSE_TIMEOUT: w = final_word(RC_RESPONSE_TIMEOUT, TX_ACK, 4'd1, pw);
          default:              w = final_word(RC_UNAVAILABLE, TX_UNAVAILABLE, 4'd1, pw);
        endcase
      end
      default: begin
        seq_phase = PH_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seq_phase = PH_IDLE;
      attempts  = 4'd0;
      own_la    = 4'd0;
      held_pa   = 16'h0000;
      wake_tx   = TX_UNAVAILABLE;
      wake_lim  = RST_WAKE_LIMIT;
      sb_lim    = RST_STANDBY_LIMIT;
      send_to   = RST_SEND_TIMEOUT;
      retry_dly = RST_RETRY_DELAY;
      wake_dly  = RST_WAKE_DELAY;
      power_to  = RST_POWER_TIMEOUT;
      due_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WAKE_LIMIT:    wake_lim  = cfg_data[3:0];
          REG_STANDBY_LIMIT: sb_lim    = cfg_data[3:0];
          REG_SEND_TIMEOUT:  send_to   = cfg_data;
          REG_RETRY_DELAY:   retry_dly = cfg_data;
          REG_WAKE_DELAY:    wake_dly  = cfg_data;
          REG_POWER_TIMEOUT: power_to  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen_w = {out_kind, header, opcode, operand_a, operand_b, operand_c, message_length,
                  wait_ms, result_code, last_outcome, attempt_count, power_state};
        if (due_words.size() == 0) begin
          $display("%0t: output word with nothing expected, expected none, actual %0h",
                   $time, seen_w);
          err_cnt++;
        end else begin
          due_w = due_words.pop_front();
          compare_field("out_kind", due_w.out_kind, seen_w.out_kind);
          compare_field("header", due_w.header, seen_w.header);
          compare_field("opcode", due_w.opcode, seen_w.opcode);
          compare_field("operand_a", due_w.op_a, seen_w.op_a);
          compare_field("operand_b", due_w.op_b, seen_w.op_b);
          compare_field("operand_c", due_w.op_c, seen_w.op_c);
          compare_field("message_length", due_w.msg_len, seen_w.msg_len);
          compare_field("wait_ms", due_w.wait_ms, seen_w.wait_ms);
          compare_field("result_code", due_w.code, seen_w.code);
          compare_field("last_outcome", due_w.outcome, seen_w.outcome);
          compare_field("attempt_count", due_w.attempts, seen_w.attempts);
          compare_field("power_state", due_w.power, seen_w.power);
          checked_cnt++;
        end
      end
      if (in_valid && in_ready) begin
        if (sequence_step(ev_kind, ev_la, ev_pa, ev_dtype, ev_tx, ev_query, ev_power,
                          next_w)) begin
          due_words.push_back(next_w);
          predicted_cnt++;
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= due_words.size();
    predicted   <= predicted_cnt;
    checked     <= checked_cnt;
  end

endmodule

// ===== sim/cec_power_command_sequencer_core_tb.sv =====
module cec_power_command_sequencer_core_tb;
  import cecpwr_pkg::*;

  localparam int CYCLE_LIMIT        = 500000;
  localparam int EVENTS_PER_SETTING = 400;
  localparam int SETTINGS_RUN       = 5;

  // kind and query codes the block has no name for
  localparam logic [2:0] EV_SPARE_LO = 3'd6;
  localparam logic [2:0] EV_SPARE_HI = 3'd7;
  localparam logic [2:0] QRY_SPARE   = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [2:0]                kind = '0;
  logic [3:0]                cec_addr = '0;
  logic [15:0]               phys_addr = '0;
  logic [7:0]                dev_type = '0;
  logic [1:0]                send_outcome = '0;
  logic [2:0]                query_outcome = '0;
  logic [7:0]                reported_power = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                out_kind;
  logic [7:0]                header;
  logic [7:0]                opcode;
  logic [7:0]                operand_a;
  logic [7:0]                operand_b;
  logic [7:0]                operand_c;
  logic [2:0]                message_length;
  logic [DEF_WAIT_BITS-1:0]  wait_ms;
  logic [2:0]                result_code;
  logic [1:0]                last_outcome;
  logic [3:0]                attempt_count;
  logic [7:0]                power_state;

  int mismatches, outstanding, predicted, checked;
  int send_idle = 0;
  int recv_stall = 0;
  int events_sent = 0;
  int cycles = 0;
  int wake_cap = 3;
  int sb_cap = 3;

  cec_power_command_sequencer_core u_dut (.*);

  cecpwr_sequence_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .ev_kind        (kind),
    .ev_la          (cec_addr),
    .ev_pa          (phys_addr),
    .ev_dtype       (dev_type),
    .ev_tx          (send_outcome),
    .ev_query       (query_outcome),
    .ev_power       (reported_power),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .header         (header),
    .opcode         (opcode),
    .operand_a      (operand_a),
    .operand_b      (operand_b),
    .operand_c      (operand_c),
    .message_length (message_length),
    .wait_ms        (wait_ms),
    .result_code    (result_code),
    .last_outcome   (last_outcome),
    .attempt_count  (attempt_count),
    .power_state    (power_state),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .predicted      (predicted),
    .checked        (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // offer one event word and hold it until taken; valid stays up for the next word
  task automatic post(input logic [2:0] k, input logic [1:0] tx, input logic [2:0] q,
                      input logic [3:0] la, input logic [15:0] pa);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    kind           <= k;
    send_outcome   <= tx;
    query_outcome  <= q;
    cec_addr       <= la;
    phys_addr      <= pa;
    dev_type       <= 8'($urandom);
    reported_power <= 8'($urandom);
    in_valid       <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    events_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [3:0] wl, input logic [3:0] sl,
                               input logic [15:0] st, input logic [15:0] rd,
                               input logic [15:0] wd, input logic [15:0] pt);
    write_reg(REG_WAKE_LIMIT, {12'h000, wl});
    write_reg(REG_STANDBY_LIMIT, {12'h000, sl});
    write_reg(REG_SEND_TIMEOUT, st);
    write_reg(REG_RETRY_DELAY, rd);
    write_reg(REG_WAKE_DELAY, wd);
    write_reg(REG_POWER_TIMEOUT, pt);
    cfg_we   <= 1'b0;
    wake_cap = (wl == 4'd0) ? 1 : wl;
    sb_cap   = (sl == 4'd0) ? 1 : sl;
  endtask

  // drive any half-done command to its final word, then drain the output side
  task automatic quiesce();
    post(EV_POWER_REPLY, 2'($urandom), 3'($urandom), 4'($urandom), 16'($urandom));
    post(EV_SEND_DONE, TX_UNAVAILABLE, 3'($urandom), 4'($urandom), 16'($urandom));
    post(EV_DELAY_DONE, 2'($urandom), 3'($urandom), 4'($urandom), 16'($urandom));
    post(EV_SEND_DONE, TX_UNAVAILABLE, 3'($urandom), 4'($urandom), 16'($urandom));
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [1:0] pick_outcome(input bit stubborn);
    int r;
    r = $urandom_range(9);
    if (stubborn) return r[0] ? TX_NO_ACK : TX_EXPIRED;
    if (r < 5) return TX_ACK;
    if (r < 7) return TX_NO_ACK;
    if (r < 9) return TX_EXPIRED;
    return TX_UNAVAILABLE;
  endfunction

  // mostly well-formed addresses: nonzero nibbles from the top, zeros below
  function automatic logic [15:0] pick_physical();
    logic [15:0] pa;
    int depth;
    if ($urandom_range(9) == 0) return 16'($urandom);
    depth = $urandom_range(4, 1);
    pa = 16'h0000;
    for (int i = 0; i < 4; i++) begin
      if (i < depth) pa[15 - 4*i -: 4] = 4'($urandom_range(15, 1));
    end
    return pa;
  endfunction

  task automatic run_session();
    int pick, n;
    bit stubborn;
    logic [3:0] la;
    pick     = $urandom_range(99);
    stubborn = ($urandom_range(3) == 0);
    if ($urandom_range(19) == 0) la = $urandom_range(1) ? LA_BROADCAST : LA_TV;
    else la = 4'($urandom_range(14, 1));
    if (pick < 8) begin
      post(3'($urandom), 2'($urandom), 3'($urandom), 4'($urandom), 16'($urandom));
    end else if (pick < 50) begin
      post(EV_START_ON, 2'($urandom), 3'($urandom), la, pick_physical());
      post(EV_SEND_DONE, pick_outcome(1'b0), 3'($urandom), 4'($urandom), 16'($urandom));
      n = stubborn ? wake_cap + 1 : $urandom_range(3, 1);
      repeat (n) begin
        post(EV_SEND_DONE, pick_outcome(stubborn), 3'($urandom), 4'($urandom),
             16'($urandom));
        post(EV_DELAY_DONE, 2'($urandom), 3'($urandom), 4'($urandom), 16'($urandom));
      end
      post(EV_SEND_DONE, pick_outcome(1'b0), 3'($urandom), 4'($urandom), 16'($urandom));
    end else if (pick < 78) begin
      post(EV_START_STANDBY, 2'($urandom), 3'($urandom), la, 16'($urandom));
      n = stubborn ? sb_cap + 1 : $urandom_range(2, 1);
      repeat (n) begin
        post(EV_SEND_DONE, pick_outcome(stubborn), 3'($urandom), 4'($urandom),
             16'($urandom));
        post(EV_DELAY_DONE, 2'($urandom), 3'($urandom), 4'($urandom), 16'($urandom));
      end
      post(EV_SEND_DONE, pick_outcome(1'b0), 3'($urandom), 4'($urandom), 16'($urandom));
    end else begin
      post(EV_START_STATUS, 2'($urandom), 3'($urandom), la, 16'($urandom));
      post(EV_POWER_REPLY, 2'($urandom), 3'($urandom), 4'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bad addresses, stray and spare kinds
    post(EV_START_STATUS, TX_ACK, QRY_OK, LA_TV, 16'h1000);
    post(EV_START_ON, TX_ACK, QRY_OK, LA_BROADCAST, 16'h1000);
    post(EV_START_ON, TX_ACK, QRY_OK, 4'd1, 16'h0000);
    post(EV_START_ON, TX_ACK, QRY_OK, 4'd14, 16'hffff);
    post(EV_START_ON, TX_ACK, QRY_OK, 4'd4, 16'h1020);
    post(EV_DELAY_DONE, TX_ACK, QRY_OK, 4'd4, 16'h1234);
    post(EV_SPARE_LO, TX_ACK, QRY_OK, 4'd4, 16'h1234);
    post(EV_SPARE_HI, TX_ACK, QRY_OK, 4'd4, 16'h1234);
    // full power-on with one retry, a start while busy and a stray reply
    post(EV_START_ON, TX_ACK, QRY_OK, 4'd4, 16'h1234);
    post(EV_START_STANDBY, TX_ACK, QRY_OK, 4'd3, 16'h0000);
    post(EV_SEND_DONE, TX_NO_ACK, QRY_OK, 4'd0, 16'h0000);
    post(EV_SEND_DONE, TX_EXPIRED, QRY_OK, 4'd0, 16'h0000);
    post(EV_POWER_REPLY, TX_ACK, QRY_OK, 4'd0, 16'h0000);
    post(EV_DELAY_DONE, TX_ACK, QRY_OK, 4'd0, 16'h0000);
    post(EV_SEND_DONE, TX_ACK, QRY_OK, 4'd0, 16'h0000);
    post(EV_DELAY_DONE, TX_ACK, QRY_OK, 4'd0, 16'h0000);
    post(EV_SEND_DONE, TX_NO_ACK, QRY_OK, 4'd0, 16'h0000);
    post(EV_START_STANDBY, TX_ACK, QRY_OK, 4'd14, 16'hffff);
    post(EV_SEND_DONE, TX_UNAVAILABLE, QRY_OK, 4'd0, 16'h0000);
    post(EV_START_STATUS, TX_ACK, QRY_OK, 4'd5, 16'h0000);
    post(EV_POWER_REPLY, TX_ACK, QRY_RESPONSE_TIMEOUT, 4'd0, 16'h0000);
    post(EV_START_STATUS, TX_ACK, QRY_OK, 4'd5, 16'h0000);
    post(EV_POWER_REPLY, TX_ACK, QRY_SPARE, 4'd0, 16'h0000);
    quiesce();

    for (int p = 0; p < SETTINGS_RUN; p++) begin
      case (p)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
          load_settings(4'd1, 4'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        end
        1: begin
          send_idle  = 85;
          recv_stall = 0;
          load_settings(4'd15, 4'd15, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        end
        2: begin
          send_idle  = 0;
          recv_stall = 85;
          load_settings(4'($urandom_range(15, 1)), 4'($urandom_range(15, 1)),
                        16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        3: begin
          send_idle  = 10;
          recv_stall = 10;
          load_settings(4'd0, 4'd0, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom));
        end
        default: begin
          send_idle  = 0;
          recv_stall = 0;
          load_settings(4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
        end
      endcase
      target = events_sent + EVENTS_PER_SETTING;
      while (events_sent < target) run_session();
      quiesce();
    end

    $display("run covered %0d event words and %0d compared result words", events_sent,
             checked);
    $display("over %0d register settings, limits and timeouts at both extremes",
             SETTINGS_RUN + 1);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== cec_power_command_sequencer_core.f =====
hw/rtl/cecpwr_pkg.sv
hw/rtl/cec_power_command_sequencer_core.sv
sim/cecpwr_sequence_checker.sv
sim/cec_power_command_sequencer_core_tb.sv
